// ===== hw/rtl/mptf_pkg.sv =====
// Package: shared types, codes and state encoding for the matrix pair timed fade unit.
package mptf_pkg;

  localparam int ELEMS = 12;
  localparam int NARROW_ELEMS = 9;
  localparam int NSTORE = 24;

  typedef enum logic [2:0] {
    MODE_WR_CUR  = 3'd0,
    MODE_WR_TGT  = 3'd1,
    MODE_SAVE    = 3'd2,
    MODE_RESTORE = 3'd3,
    MODE_READ    = 3'd4,
    MODE_START   = 3'd5,
    MODE_TICK    = 3'd6,
    MODE_NONE    = 3'd7
  } mode_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               matrix_sel;
    logic [3:0]         element;
    logic signed [31:0] value;
    logic               fade_kind;
  } in_word_t;

  typedef struct packed {
    logic               out_matrix;
    logic [3:0]         out_element;
    logic signed [31:0] out_value;
    logic               last;
    logic               fade_active;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_TICK_END,
    ST_EMIT_RD,
    ST_EMIT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CP_SAVE,
    CP_RESTORE,
    CP_START
  } copy_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_item;
    logic       do_write;
    logic       copy_en;
    copy_t      copy_kind;
    logic       clr_idx;
    logic       inc_idx;
    logic       load_elem;
    logic       mul_step;
    logic       div_start;
    logic       div_step;
    logic       store_res;
    logic       tick_end;
    logic       start_fade;
    logic       load_read;
    logic       load_emit;
    logic       load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       idx_last;
    logic       mul_done;
    logic       div_done;
    logic       running;
  } dp_stat_t;

  function automatic logic [31:0] fit(input logic [31:0] v, input logic [3:0] elem);
    if (elem < 4'(NARROW_ELEMS))
      fit = {{16{v[15]}}, v[15:0]};
    else
      fit = v;
  endfunction

endpackage

// ===== hw/rtl/matrix_pair_timed_fade_unit.sv =====
// Top level of the matrix pair timed fade unit.
// Tick: per element a load, serial multiply steps, a divider start, serial divide steps and
// a store, over all 24 elements, then 12 output words.
// The serial shift-add multiplier and restoring divider set the tick time.
// Reset (synchronous, rst_n low) clears all stores, frame count and fade state.
module matrix_pair_timed_fade_unit #(
  parameter int DURATION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mptf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mptf_pkg::out_word_t out_data
);
  import mptf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mptf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mptf_datapath #(.DURATION_BITS(DURATION_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_data)
  );

endmodule

// ===== hw/rtl/mptf_datapath.sv =====
// Datapath: element stores, serial multiplier, serial divider and output register.
module mptf_datapath #(
  parameter int DURATION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mptf_pkg::in_word_t  in_word,
  input  mptf_pkg::dp_cmd_t   cmd,
  output mptf_pkg::dp_stat_t  stat,
  output mptf_pkg::out_word_t out_word
);
  import mptf_pkg::*;

  localparam int FW = DURATION_BITS + 1;
  localparam int PW = 33 + FW;

  logic [31:0] cur_r [NSTORE];
  logic [31:0] sav_r [NSTORE];
  logic [31:0] sta_r [NSTORE];
  logic [31:0] tgt_r [NSTORE];

  logic [FW-1:0]            frame_r;
  logic [DURATION_BITS-1:0] len_r;
  logic                     run_r;
  logic                     kind_r;

  in_word_t    item_r;
  logic [4:0]  idx_r;
  logic [3:0]  elem_r;

  logic signed [32:0] sv_r;
  logic signed [32:0] diff_r;
  logic               neg_r;
  logic [32:0]        mag_r;

  logic [PW-1:0]      prod_r;
  logic [FW-1:0]      mcnt_r;
  logic [$clog2(FW+1)-1:0] mstep_r;

  logic [PW-1:0]      quo_r;
  logic [DURATION_BITS:0] rem_r;
  logic [$clog2(PW+1)-1:0] dstep_r;

  out_word_t out_r;

  logic [4:0] widx;
  logic [DURATION_BITS:0] rem_sh;
  logic [DURATION_BITS:0] rem_sub;
  logic [63:0] res;
  logic [FW-1:0] frame_nxt;
  logic [DURATION_BITS-1:0] dlen;

  assign widx = item_r.matrix_sel ? 5'(item_r.element + 4'd12) : 5'(item_r.element);
  assign rem_sh = {rem_r[DURATION_BITS-1:0], quo_r[PW-1]};
  assign rem_sub = rem_sh - {1'b0, len_r};
  assign frame_nxt = frame_r + 1'b1;

  always_comb begin
    if (item_r.value[31])
      dlen = '0;
    else if (item_r.value[30:0] > 31'({DURATION_BITS{1'b1}}))
      dlen = '1;
    else
      dlen = item_r.value[DURATION_BITS-1:0];
  end

  always_comb begin
    if (len_r == '0)
      res = 64'(sv_r + diff_r);
    else if (neg_r)
      res = 64'(sv_r) - 64'(quo_r);
    else
      res = 64'(sv_r) + 64'(quo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTORE; i++) begin
        cur_r[i] <= '0;
        sav_r[i] <= '0;
        sta_r[i] <= '0;
        tgt_r[i] <= '0;
      end
      frame_r <= '0;
      len_r   <= '0;
      run_r   <= 1'b0;
      kind_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cmd.do_write && item_r.element < 4'(ELEMS)) begin
        if (item_r.mode == MODE_WR_CUR)
          cur_r[widx] <= fit(item_r.value, item_r.element);
        else
          tgt_r[widx] <= fit(item_r.value, item_r.element);
      end
      if (cmd.copy_en) begin
        case (cmd.copy_kind)
          CP_SAVE:    sav_r[idx_r] <= cur_r[idx_r];
          CP_RESTORE: cur_r[idx_r] <= sav_r[idx_r];
          CP_START:   sta_r[idx_r] <= cur_r[idx_r];
          default:    ;
        endcase
      end
      if (cmd.start_fade) begin
        len_r   <= dlen;
        frame_r <= '0;
        kind_r  <= item_r.fade_kind;
        run_r   <= 1'b1;
      end
      if (cmd.store_res)
        cur_r[idx_r] <= fit(res[31:0], elem_r);
      if (cmd.tick_end) begin
        frame_r <= frame_nxt;
        if (frame_nxt > {1'b0, len_r})
          run_r <= 1'b0;
      end
      if (cmd.clr_idx)
        idx_r <= '0;
      else if (cmd.inc_idx)
        idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item)
      item_r <= in_word;
    if (cmd.load_elem) begin
      elem_r <= (idx_r >= 5'd12) ? 4'(idx_r - 5'd12) : idx_r[3:0];
      sv_r   <= {sta_r[idx_r][31], sta_r[idx_r]};
      if (kind_r) begin
        diff_r <= {tgt_r[idx_r][31], tgt_r[idx_r]};
        neg_r  <= tgt_r[idx_r][31];
        mag_r  <= tgt_r[idx_r][31] ? 33'(-{tgt_r[idx_r][31], tgt_r[idx_r]})
                                   : {1'b0, tgt_r[idx_r]};
      end else begin
        diff_r <= {tgt_r[idx_r][31], tgt_r[idx_r]} - {sta_r[idx_r][31], sta_r[idx_r]};
        neg_r  <= ($signed({tgt_r[idx_r][31], tgt_r[idx_r]}) <
                   $signed({sta_r[idx_r][31], sta_r[idx_r]}));
        mag_r  <= ($signed({tgt_r[idx_r][31], tgt_r[idx_r]}) <
                   $signed({sta_r[idx_r][31], sta_r[idx_r]}))
                  ? {sta_r[idx_r][31], sta_r[idx_r]} - {tgt_r[idx_r][31], tgt_r[idx_r]}
                  : {tgt_r[idx_r][31], tgt_r[idx_r]} - {sta_r[idx_r][31], sta_r[idx_r]};
      end
      prod_r  <= '0;
      mcnt_r  <= frame_r;
      mstep_r <= '0;
    end
    if (cmd.mul_step) begin
      // shift-add, frame bits msb first
      prod_r  <= (prod_r << 1) + (mcnt_r[FW-1] ? PW'(mag_r) : '0);
      mcnt_r  <= mcnt_r << 1;
      mstep_r <= mstep_r + 1'b1;
    end
    if (cmd.div_start) begin
      quo_r   <= prod_r;
      rem_r   <= '0;
      dstep_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, len_r}) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[PW-2:0], 1'b0};
      end
      dstep_r <= dstep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      out_r.out_matrix  <= item_r.matrix_sel;
      out_r.out_element <= item_r.element;
      out_r.out_value   <= (item_r.element < 4'(ELEMS)) ? cur_r[widx] : '0;
      out_r.last        <= 1'b1;
      out_r.fade_active <= run_r;
    end
    if (cmd.load_emit) begin
      out_r.out_matrix  <= 1'b0;
      out_r.out_element <= idx_r[3:0];
      out_r.out_value   <= cur_r[idx_r];
      out_r.last        <= (idx_r == 5'(ELEMS - 1));
      out_r.fade_active <= run_r;
    end
  end

  assign stat.idx_last = cmd.load_out ? (idx_r == 5'(ELEMS - 1)) : (idx_r == 5'(NSTORE - 1));
  assign stat.mul_done = (mstep_r == ($clog2(FW+1))'(FW - 1));
  assign stat.div_done = (dstep_r == ($clog2(PW+1))'(PW - 1));
  assign stat.running  = run_r;
  assign out_word = out_r;

endmodule

// ===== hw/rtl/mptf_ctrl.sv =====
// Controller: sequencing state machine for commands, copies, fade ticks and output words.
module mptf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  output logic               out_valid,
  input  logic               out_stall,
  input  mptf_pkg::dp_stat_t stat,
  output mptf_pkg::dp_cmd_t  cmd
);
  import mptf_pkg::*;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   ov_r, ov_nxt;
  logic   emit_r, emit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_NONE;
      ov_r    <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ov_r    <= ov_nxt;
      emit_r  <= emit_nxt;
    end
  end

  assign out_valid = ov_r;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    ov_nxt    = ov_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    cmd.copy_kind = CP_SAVE;
    if (ov_r && !out_stall)
      ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          mode_nxt  = mode_t'(in_mode);
          cmd.clr_idx = 1'b1;
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        case (mode_r)
          MODE_WR_CUR, MODE_WR_TGT: begin
            cmd.do_write = 1'b1;
            state_nxt = ST_IDLE;
          end
          MODE_SAVE, MODE_RESTORE, MODE_START: begin
            cmd.copy_en = 1'b1;
            cmd.copy_kind = (mode_r == MODE_SAVE) ? CP_SAVE :
                            (mode_r == MODE_RESTORE) ? CP_RESTORE : CP_START;
            cmd.inc_idx = 1'b1;
            if (stat.idx_last) begin
              cmd.start_fade = (mode_r == MODE_START);
              state_nxt = ST_IDLE;
            end
          end
          MODE_READ: state_nxt = ST_EMIT_RD;
          MODE_TICK: state_nxt = stat.running ? ST_LOAD : ST_IDLE;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_LOAD: begin
        cmd.load_elem = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done)
          state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_STORE;
        emit_nxt  = 1'b0;
      end
      ST_STORE: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          emit_nxt = 1'b1;
        end
        if (emit_r) begin
          cmd.div_step  = 1'b0;
          cmd.store_res = 1'b1;
          cmd.inc_idx   = 1'b1;
          emit_nxt = 1'b0;
          state_nxt = stat.idx_last ? ST_TICK_END : ST_LOAD;
        end
      end
      ST_TICK_END: begin
        cmd.tick_end = 1'b1;
        cmd.clr_idx  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT_RD: begin
        if (!ov_r || !out_stall) begin
          cmd.load_read = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd.load_out = 1'b1;
        if (!ov_r || !out_stall) begin
          cmd.load_emit = 1'b1;
          cmd.inc_idx = 1'b1;
          ov_nxt = 1'b1;
          if (stat.idx_last)
            state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || !out_stall)
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== tb/matrix_pair_timed_fade_unit_tb.sv =====
// Testbench for the matrix pair timed fade unit: directed and random words, scoreboard check.
`timescale 1ns / 1ps

module matrix_pair_timed_fade_unit_tb;
  import mptf_pkg::*;

  localparam int DUR_BITS = 16;
  localparam int DUR_MAX = (1 << DUR_BITS) - 1;
  localparam int CYCLE_LIMIT = 4000000;

  class fade_scoreboard;
    logic [31:0] cur_mat[NSTORE];
    logic [31:0] saved_mat[NSTORE];
    logic [31:0] start_mat[NSTORE];
    logic [31:0] target_mat[NSTORE];
    longint frame;
    longint length;
    bit running;
    bit kind_delta;
    out_word_t pending_q[$];
    int mismatches;
    int matched;
    int ticks_run;

    function new();
      for (int k = 0; k < NSTORE; k++) begin
        cur_mat[k] = '0;
        saved_mat[k] = '0;
        start_mat[k] = '0;
        target_mat[k] = '0;
      end
      frame = 0;
      length = 0;
      running = 0;
      kind_delta = 0;
      mismatches = 0;
      matched = 0;
      ticks_run = 0;
    endfunction

    function logic [31:0] narrow(input logic [31:0] v, input int e);
      return (e < NARROW_ELEMS) ? {{16{v[15]}}, v[15:0]} : v;
    endfunction

    function logic [31:0] blend(input logic [31:0] s, input logic [31:0] t, input int e);
      longint sv, tv, diff, mag, q, r;
      sv = longint'($signed(s));
      tv = longint'($signed(t));
      diff = kind_delta ? tv : tv - sv;
      if (length == 0) begin
        r = sv + diff;
      end else begin
        mag = (diff < 0) ? -diff : diff;
        q = mag * frame / length;
        r = (diff < 0) ? sv - q : sv + q;
      end
      return narrow(r[31:0], e);
    endfunction

    function void note_input(input in_word_t w);
      int idx;
      longint d;
      out_word_t o;
      idx = w.matrix_sel * ELEMS + w.element;
      case (mode_t'(w.mode))
        MODE_WR_CUR: if (w.element < ELEMS) cur_mat[idx] = narrow(w.value, w.element);
        MODE_WR_TGT: if (w.element < ELEMS) target_mat[idx] = narrow(w.value, w.element);
        MODE_SAVE: saved_mat = cur_mat;
        MODE_RESTORE: cur_mat = saved_mat;
        MODE_READ: begin
          o.out_matrix = w.matrix_sel;
          o.out_element = w.element;
          o.out_value = (w.element < ELEMS) ? cur_mat[idx] : '0;
          o.last = 1'b1;
          o.fade_active = running;
          pending_q.push_back(o);
        end
        MODE_START: begin
          d = longint'(w.value);
          if (d < 0) d = 0;
          if (d > DUR_MAX) d = DUR_MAX;
          start_mat = cur_mat;
          length = d;
          frame = 0;
          kind_delta = w.fade_kind;
          running = 1;
        end
        MODE_TICK: begin
          if (running) begin
            for (int k = 0; k < NSTORE; k++)
              cur_mat[k] = blend(start_mat[k], target_mat[k], k % ELEMS);
            frame++;
            if (frame > length) running = 0;
            ticks_run++;
            for (int k = 0; k < ELEMS; k++) begin
              o.out_matrix = 1'b0;
              o.out_element = 4'(k);
              o.out_value = cur_mat[k];
              o.last = (k == ELEMS - 1);
              o.fade_active = running;
              pending_q.push_back(o);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(input out_word_t r);
      out_word_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: mat=%0d el=%0d val=%h last=%0d act=%0d",
                   r.out_matrix, r.out_element, r.out_value, r.last, r.fade_active);
        return;
      end
      e = pending_q.pop_front();
      if (r.out_matrix !== e.out_matrix || r.out_element !== e.out_element ||
          r.out_value !== e.out_value || r.last !== e.last ||
          r.fade_active !== e.fade_active) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp mat=%0d el=%0d val=%h last=%0d act=%0d / got mat=%0d el=%0d val=%h last=%0d act=%0d",
                   e.out_matrix, e.out_element, e.out_value, e.last, e.fade_active,
                   r.out_matrix, r.out_element, r.out_value, r.last, r.fade_active);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;

  fade_scoreboard sb;
  int cycles;
  int items_sent;
  int hold_cycles;
  bit tx_no_gaps;
  bit rx_no_gaps;

  matrix_pair_timed_fade_unit #(.DURATION_BITS(DUR_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic int pick_gap(input bit none);
    int r;
    r = $urandom_range(0, 99);
    if (none || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: long hold when requested, else random stalls
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
        @(posedge clk);
      end else begin
        int n;
        n = pick_gap(rx_no_gaps);
        if (n == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  function automatic in_word_t mk(input mode_t m, input logic sel, input logic [3:0] el,
                                  input logic [31:0] v, input logic kind);
    in_word_t w;
    w.mode = m;
    w.matrix_sel = sel;
    w.element = el;
    w.value = v;
    w.fade_kind = kind;
    return w;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_7fff;
      4: return 32'hffff_8000;
      5: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input in_word_t w);
    int n;
    in_valid <= 1'b1;
    in_data <= w;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_input(w);
    items_sent++;
    n = pick_gap(tx_no_gaps);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic fade_run();
    int nw, d, nt;
    nw = $urandom_range(0, 6);
    repeat (nw)
      send(mk(($urandom_range(0, 1) ? MODE_WR_TGT : MODE_WR_CUR), $urandom_range(0, 1),
              $urandom_range(0, 11), rand_value(), 1'b0));
    case ($urandom_range(0, 19))
      0: d = -$urandom_range(1, 1000);
      1: d = 32'h7fff_0000 + $urandom_range(0, 255);
      default: d = $urandom_range(0, 4);
    endcase
    send(mk(MODE_START, $urandom_range(0, 1), $urandom_range(0, 15), d, $urandom_range(0, 1)));
    nt = (d < 0) ? 2 : (d > 8) ? 3 : d + 1 + $urandom_range(0, 1);
    repeat (nt) begin
      if ($urandom_range(0, 3) == 0)
        send(mk(MODE_READ, $urandom_range(0, 1), $urandom_range(0, 15), $urandom, 1'b0));
      send(mk(MODE_TICK, $urandom_range(0, 1), $urandom_range(0, 15), $urandom,
              $urandom_range(0, 1)));
    end
  endtask

  task automatic noise_word();
    send(mk(mode_t'($urandom_range(0, 7)), $urandom_range(0, 1), $urandom_range(0, 15),
            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : rand_value(),
            $urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    cycles = 0;
    items_sent = 0;
    hold_cycles = 0;
    tx_no_gaps = 0;
    rx_no_gaps = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, all modes, corner cases
    send(mk(MODE_WR_CUR, 0, 0, 32'h8000_7fff, 0));
    send(mk(MODE_WR_CUR, 1, 8, 32'h0000_8000, 1));
    send(mk(MODE_WR_CUR, 0, 11, 32'h8000_0000, 0));
    send(mk(MODE_WR_TGT, 0, 0, 32'h7fff_8000, 0));
    send(mk(MODE_WR_TGT, 1, 9, 32'h7fff_ffff, 1));
    send(mk(MODE_WR_TGT, 0, 11, 32'h7fff_ffff, 0));
    send(mk(MODE_WR_CUR, 1, 15, 32'hffff_ffff, 0));
    send(mk(MODE_READ, 0, 0, 0, 0));
    send(mk(MODE_READ, 1, 8, 0, 0));
    send(mk(MODE_READ, 1, 15, 32'hffff_ffff, 1));
    send(mk(MODE_SAVE, 0, 0, 0, 0));
    send(mk(MODE_NONE, 1, 3, 32'h1234_5678, 1));
    send(mk(MODE_TICK, 0, 0, 0, 0));
    send(mk(MODE_START, 0, 0, 0, 0));
    send(mk(MODE_TICK, 0, 0, 0, 0));
    send(mk(MODE_TICK, 0, 0, 0, 0));
    send(mk(MODE_RESTORE, 0, 0, 0, 0));
    send(mk(MODE_READ, 0, 11, 0, 0));
    send(mk(MODE_START, 1, 0, 32'hffff_fffb, 1));
    send(mk(MODE_TICK, 0, 0, 0, 0));
    send(mk(MODE_START, 0, 0, 32'h7fff_ffff, 0));
    send(mk(MODE_TICK, 0, 0, 0, 0));
    send(mk(MODE_READ, 1, 9, 0, 0));
    send(mk(MODE_START, 0, 0, 2, 1));
    repeat (3) send(mk(MODE_TICK, 0, 0, 0, 0));
    drain();

    // backpressure: receiver holds, sender keeps offering
    hold_cycles = 3000;
    tx_no_gaps = 1;
    send(mk(MODE_START, 0, 0, 5, 0));
    repeat (4) send(mk(MODE_READ, $urandom_range(0, 1), $urandom_range(0, 11), 0, 0));
    repeat (3) send(mk(MODE_TICK, 0, 0, 0, 0));
    tx_no_gaps = 0;
    drain();

    while (items_sent < 460) begin
      if (items_sent > 200 && items_sent < 260) begin
        tx_no_gaps = 1;
        rx_no_gaps = 1;
      end else begin
        tx_no_gaps = 0;
        rx_no_gaps = 0;
      end
      if ($urandom_range(0, 9) < 7) fade_run();
      else repeat ($urandom_range(1, 4)) noise_word();
      if ($urandom_range(0, 19) == 0) drain();
    end

    drain();
    $display("run covered %0d words in, %0d words out, %0d fade ticks",
             items_sent, sb.matched, sb.ticks_run);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatches: %0d, left over: %0d", sb.mismatches, sb.pending_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
